FILE: rtl/rfc_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helpers of the reader frame checker
package rfc_pkg;

  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int HEX_W     = 7;
  localparam int EPC_BYTES = 12;
  localparam int POS_W     = 5;
  localparam int CHAR_W    = 5;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  localparam logic [BYTE_W-1:0] HDR_VAL  = 8'haa;
  localparam logic [BYTE_W-1:0] TYPE_VAL = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_VAL  = 8'h22;
  localparam logic [BYTE_W-1:0] END_VAL  = 8'h8e;

  localparam logic [POS_W-1:0] POS_HDR   = 5'd0;
  localparam logic [POS_W-1:0] POS_TYPE  = 5'd1;
  localparam logic [POS_W-1:0] POS_CMD   = 5'd2;
  localparam logic [POS_W-1:0] EPC_FIRST = 5'd8;
  localparam logic [POS_W-1:0] EPC_END   = 5'd20;
  localparam logic [POS_W-1:0] SUM_POS   = 5'd22;
  localparam logic [POS_W-1:0] END_POS   = 5'd23;

  localparam logic [CHAR_W-1:0] CHAR_LAST = 5'd23;

  localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HDR  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TYPE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CMD  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SUM  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_END  = 3'd5;

  typedef logic [EPC_BYTES-1:0][BYTE_W-1:0] epc_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    epc_t                epc;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [HEX_W-1:0] nib_to_ascii(input logic [3:0] v);
    logic [HEX_W-1:0] r;
    if (v < 4'd10) begin
      r = 7'd48 + {3'b000, v};
    end else begin
      r = 7'd87 + {3'b000, v};
    end
    return r;
  endfunction

endpackage

FILE: rtl/rfc_byte_if.sv
`timescale 1ns / 1ps
// input channel: one frame byte per transfer
interface rfc_byte_if;
  logic                       valid;
  logic                       ready;
  logic [rfc_pkg::BYTE_W-1:0] frame_byte;
  logic                       first_byte;

  modport source (output valid, frame_byte, first_byte, input ready);
  modport sink (input valid, frame_byte, first_byte, output ready);
endinterface

FILE: rtl/rfc_res_if.sv
`timescale 1ns / 1ps
// output channel: one result character per transfer
interface rfc_res_if;
  logic                         valid;
  logic                         ready;
  logic [rfc_pkg::STATUS_W-1:0] status;
  logic [rfc_pkg::HEX_W-1:0]    hex_char;
  logic                         last;

  modport source (output valid, status, hex_char, last, input ready);
  modport sink (input valid, status, hex_char, last, output ready);
endinterface

FILE: rtl/rfc_front.sv
`timescale 1ns / 1ps
// front end: frame position tracking, header and checksum checks, epc capture
module rfc_front (
  input  logic             clk,
  input  logic             rst,
  rfc_byte_if.sink         byte_in,
  input  rfc_pkg::q_stat_t q_stat,
  output logic             push,
  output rfc_pkg::job_t    job
);
  import rfc_pkg::*;

  logic [POS_W-1:0]    pos;
  logic [BYTE_W-1:0]   sum;
  logic [STATUS_W-1:0] err;
  logic                in_frame;
  epc_t                epc;

  logic                accept;
  logic                active;
  logic [POS_W-1:0]    p;
  logic [BYTE_W-1:0]   sum_cur;
  logic [STATUS_W-1:0] err_cur;
  logic [STATUS_W-1:0] code;
  logic [STATUS_W-1:0] err_next;
  logic [POS_W-1:0]    epc_off;
  logic [BYTE_W-1:0]   b;

  // hold off only a closing byte that would find the queue full
  assign byte_in.ready = !(in_frame && (pos == END_POS) && q_stat.full);
  assign accept = byte_in.valid && byte_in.ready;
  assign b      = byte_in.frame_byte;

  always_comb begin
    active  = byte_in.first_byte || in_frame;
    p       = byte_in.first_byte ? POS_HDR : pos;
    sum_cur = byte_in.first_byte ? '0 : sum;
    err_cur = byte_in.first_byte ? ST_OK : err;
    epc_off = p - EPC_FIRST;
    code    = ST_OK;
    if (p == POS_HDR && b != HDR_VAL) begin
      code = ST_HDR;
    end else if (p == POS_TYPE && b != TYPE_VAL) begin
      code = ST_TYPE;
    end else if (p == POS_CMD && b != CMD_VAL) begin
      code = ST_CMD;
    end else if (p == SUM_POS && b != sum_cur) begin
      code = ST_SUM;
    end else if (p == END_POS && b != END_VAL) begin
      code = ST_END;
    end
    err_next = (err_cur != ST_OK) ? err_cur : code;
  end

  assign push       = accept && active && (p == END_POS);
  assign job.status = err_next;
  assign job.epc    = epc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      sum      <= '0;
      err      <= ST_OK;
      in_frame <= 1'b0;
    end else if (accept && active) begin
      err <= err_next;
      if (p >= POS_TYPE && p < SUM_POS) begin
        sum <= sum_cur + b;
      end else begin
        sum <= sum_cur;
      end
      if (p == END_POS) begin
        pos      <= '0;
        in_frame <= 1'b0;
      end else begin
        pos      <= p + 5'd1;
        in_frame <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active && p >= EPC_FIRST && p < EPC_END) begin
      epc[epc_off[3:0]] <= b;
    end
  end

  a_idle_pos: assert property (@(posedge clk) disable iff (rst) !in_frame |-> pos == '0)
    else $error("position not cleared outside a frame");
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full)
    else $error("frame result pushed into a full queue");

endmodule

FILE: rtl/rfc_queue.sv
`timescale 1ns / 1ps
// two-entry queue of finished frames between front and back end
module rfc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rfc_pkg::job_t    job_in,
  input  logic             pop,
  output rfc_pkg::job_t    head,
  output rfc_pkg::q_stat_t q_stat
);
  import rfc_pkg::*;

  job_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign head         = mem[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == Q_CNT_W'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= job_in;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("pop from empty queue");

endmodule

FILE: rtl/rfc_back.sv
`timescale 1ns / 1ps
// back end: turns a finished frame into an error result or 24 hex characters
module rfc_back (
  input  logic             clk,
  input  logic             rst,
  input  rfc_pkg::q_stat_t q_stat,
  input  rfc_pkg::job_t    head,
  output logic             pop,
  rfc_res_if.source        res_out
);
  import rfc_pkg::*;

  logic [CHAR_W-1:0]   idx;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [HEX_W-1:0]    out_hex;
  logic                out_last;

  logic                load;
  logic                is_err;
  logic [BYTE_W-1:0]   cur_byte;
  logic [3:0]          nib;

  assign load     = !q_stat.empty && (!out_valid || res_out.ready);
  assign is_err   = head.status != ST_OK;
  assign cur_byte = head.epc[idx[CHAR_W-1:1]];
  // high nibble on even characters
  assign nib      = idx[0] ? cur_byte[3:0] : cur_byte[7:4];
  assign pop      = load && (is_err || idx == CHAR_LAST);

  assign res_out.valid    = out_valid;
  assign res_out.status   = out_status;
  assign res_out.hex_char = out_hex;
  assign res_out.last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= pop ? '0 : idx + 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= head.status;
      out_hex    <= is_err ? '0 : nib_to_ascii(nib);
      out_last   <= pop;
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_last && out_hex == '0)
    else $error("error result not a single last transfer");
  a_mid_frame: assert property (@(posedge clk) disable iff (rst)
    idx != '0 |-> !q_stat.empty && !is_err)
    else $error("character count running without a good frame");

endmodule

FILE: rtl/reader_frame_check_hex_epc.sv
`timescale 1ns / 1ps
// reader frame checker: 24-byte response frames in, error code or epc hex characters out
// first result: queued, then registered at the output once the closing byte is transferred
// throughput: one byte per cycle in, one result per cycle out while the sink is ready;
// a good frame yields 24 characters, and a closing byte waits only while two frames queue
// reset: synchronous active-high rst closes any open frame and empties the queue
module reader_frame_check_hex_epc (
  input logic       clk,
  input logic       rst,
  rfc_byte_if.sink  byte_in,
  rfc_res_if.source res_out
);
  import rfc_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  job_t    job;
  job_t    head;

  rfc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .q_stat  (q_stat),
    .push    (push),
    .job     (job)
  );

  rfc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .job_in (job),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  rfc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .head    (head),
    .pop     (pop),
    .res_out (res_out)
  );

endmodule

FILE: sim/tb_reader_frame_check_hex_epc.sv
`timescale 1ns / 1ps
// testbench of the reader frame checker: frame table, random frames and a result scoreboard
module tb_reader_frame_check_hex_epc;
  import rfc_pkg::*;

  localparam int FRAME_LEN    = 24;
  localparam int RAND_ITEMS   = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_GAP      = 18;

  // corruption mask bits, one per frame check
  localparam logic [4:0] BAD_HDR  = 5'b00001;
  localparam logic [4:0] BAD_TYPE = 5'b00010;
  localparam logic [4:0] BAD_CMD  = 5'b00100;
  localparam logic [4:0] BAD_SUM  = 5'b01000;
  localparam logic [4:0] BAD_END  = 5'b10000;

  localparam logic [HEX_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [HEX_W-1:0] CHAR_F    = 7'h66;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RAMP, FILL_RAND} fill_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HEX_W-1:0]    hex_char;
    logic                last;
  } res_t;

  typedef struct {
    fill_e               fill;
    logic [4:0]          bad;
    int                  len;
    int                  stray;
    bit                  typed;
    logic [STATUS_W-1:0] t_status;
    logic [HEX_W-1:0]    t_char;
  } frame_row_t;

  logic clk;
  logic rst;

  rfc_byte_if byte_ch ();
  rfc_res_if  res_ch ();

  reader_frame_check_hex_epc dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_ch),
    .res_out (res_ch)
  );

  // checker state mirrored from the block
  logic [POS_W-1:0]    frm_pos;
  logic [BYTE_W-1:0]   frm_sum;
  logic [STATUS_W-1:0] frm_err;
  logic [BYTE_W-1:0]   epc_copy [EPC_BYTES];
  logic                frm_open;

  res_t       char_exp_q[$];
  res_t       frame_out_q[$];
  frame_row_t frame_plan_q[$];
  logic [BYTE_W-1:0] frame_buf [FRAME_LEN];

  int fail_count  = 0;
  int idle_cycles = 0;
  int frame_bytes = 0;
  bit tx_steady   = 0;
  bit rx_steady   = 0;
  bit hold_req    = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_bad(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  function automatic logic [HEX_W-1:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      return CHAR_ZERO + n;
    end
    return 7'h61 + (n - 4'd10);
  endfunction

  function automatic logic [STATUS_W-1:0] keep_first(input logic [STATUS_W-1:0] cur,
                                                     input logic [STATUS_W-1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  // advance the mirrored state by one accepted byte, results go to frame_out_q
  task automatic track_byte(input logic [BYTE_W-1:0] b, input logic f);
    res_t r;
    frame_out_q.delete();
    if (f) begin
      frm_pos  = '0;
      frm_sum  = '0;
      frm_err  = ST_OK;
      frm_open = 1'b1;
    end
    if (frm_open) begin
      if (frm_pos == POS_HDR && b != HDR_VAL) frm_err = keep_first(frm_err, ST_HDR);
      if (frm_pos == POS_TYPE && b != TYPE_VAL) frm_err = keep_first(frm_err, ST_TYPE);
      if (frm_pos == POS_CMD && b != CMD_VAL) frm_err = keep_first(frm_err, ST_CMD);
      if (frm_pos >= POS_TYPE && frm_pos < SUM_POS) frm_sum = frm_sum + b;
      if (frm_pos >= EPC_FIRST && frm_pos < EPC_END) epc_copy[int'(frm_pos - EPC_FIRST)] = b;
      if (frm_pos == SUM_POS && b != frm_sum) frm_err = keep_first(frm_err, ST_SUM);
      if (frm_pos != END_POS) begin
        frm_pos = frm_pos + 1'b1;
      end else begin
        if (b != END_VAL) frm_err = keep_first(frm_err, ST_END);
        frm_open = 1'b0;
        frm_pos  = '0;
        if (frm_err != ST_OK) begin
          r.status   = frm_err;
          r.hex_char = '0;
          r.last     = 1'b1;
          frame_out_q.push_back(r);
        end else begin
          for (int k = 0; k < EPC_BYTES; k++) begin
            r.status   = ST_OK;
            r.hex_char = hex_digit(epc_copy[k][7:4]);
            r.last     = 1'b0;
            frame_out_q.push_back(r);
            r.hex_char = hex_digit(epc_copy[k][3:0]);
            r.last     = (k == EPC_BYTES - 1);
            frame_out_q.push_back(r);
          end
        end
      end
    end
  endtask

  function automatic void add_row(input fill_e fill, input logic [4:0] bad, input int len,
                                  input int stray, input bit typed,
                                  input logic [STATUS_W-1:0] t_status,
                                  input logic [HEX_W-1:0] t_char);
    frame_row_t row;
    row.fill     = fill;
    row.bad      = bad;
    row.len      = len;
    row.stray    = stray;
    row.typed    = typed;
    row.t_status = t_status;
    row.t_char   = t_char;
    frame_plan_q.push_back(row);
  endfunction

  function automatic void build_frame(input fill_e fill, input logic [4:0] bad);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] ramp;
    for (int i = 0; i < FRAME_LEN; i++) frame_buf[i] = BYTE_W'($urandom_range(0, 255));
    frame_buf[POS_HDR]  = HDR_VAL;
    frame_buf[POS_TYPE] = TYPE_VAL;
    frame_buf[POS_CMD]  = CMD_VAL;
    ramp = 8'h01;
    for (int k = 0; k < EPC_BYTES; k++) begin
      case (fill)
        FILL_ZERO: frame_buf[EPC_FIRST + k] = 8'h00;
        FILL_ONES: frame_buf[EPC_FIRST + k] = 8'hff;
        FILL_RAMP: frame_buf[EPC_FIRST + k] = ramp;
        default: ;
      endcase
      ramp = ramp + 8'h22;
    end
    if (bad & BAD_HDR)
      frame_buf[POS_HDR] = frame_buf[POS_HDR] ^ BYTE_W'($urandom_range(1, 255));
    if (bad & BAD_TYPE)
      frame_buf[POS_TYPE] = frame_buf[POS_TYPE] ^ BYTE_W'($urandom_range(1, 255));
    if (bad & BAD_CMD)
      frame_buf[POS_CMD] = frame_buf[POS_CMD] ^ BYTE_W'($urandom_range(1, 255));
    // checksum covers every byte from the type byte up to the checksum, as sent
    acc = '0;
    for (int i = POS_TYPE; i < SUM_POS; i++) acc = acc + frame_buf[i];
    frame_buf[SUM_POS] = acc;
    if (bad & BAD_SUM)
      frame_buf[SUM_POS] = frame_buf[SUM_POS] ^ BYTE_W'($urandom_range(1, 255));
    frame_buf[END_POS] = END_VAL;
    if (bad & BAD_END)
      frame_buf[END_POS] = frame_buf[END_POS] ^ BYTE_W'($urandom_range(1, 255));
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic f, input bit use_typed,
                           input logic [STATUS_W-1:0] t_status,
                           input logic [HEX_W-1:0] t_char);
    int   gap;
    res_t r;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) @(negedge clk);
    byte_ch.valid      = 1'b1;
    byte_ch.frame_byte = b;
    byte_ch.first_byte = f;
    do @(posedge clk); while (!byte_ch.ready);
    track_byte(b, f);
    if (use_typed && frame_out_q.size() > 0) begin
      if (t_status != ST_OK) begin
        r.status   = t_status;
        r.hex_char = '0;
        r.last     = 1'b1;
        char_exp_q.push_back(r);
      end else begin
        for (int k = 0; k < 2 * EPC_BYTES; k++) begin
          r.status   = ST_OK;
          r.hex_char = t_char;
          r.last     = (k == 2 * EPC_BYTES - 1);
          char_exp_q.push_back(r);
        end
      end
    end else begin
      foreach (frame_out_q[k]) char_exp_q.push_back(frame_out_q[k]);
    end
    @(negedge clk);
    byte_ch.valid = 1'b0;
  endtask

  task automatic send_frame(input frame_row_t row);
    for (int i = 0; i < row.stray; i++) begin
      send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0, ST_OK, '0);
    end
    build_frame(row.fill, row.bad);
    for (int i = 0; i < row.len; i++) begin
      send_byte(frame_buf[i], i == 0, row.typed && i == END_POS, row.t_status, row.t_char);
      frame_bytes++;
    end
  endtask

  task automatic check_result(input logic [STATUS_W-1:0] st, input logic [HEX_W-1:0] hc,
                              input logic l);
    res_t want;
    if (char_exp_q.size() == 0) begin
      report_bad("result with none expected, status", st, 0);
    end else begin
      want = char_exp_q.pop_front();
      if (st !== want.status) report_bad("status", st, want.status);
      if (hc !== want.hex_char) report_bad("hex_char", hc, want.hex_char);
      if (l !== want.last) report_bad("last", l, want.last);
    end
  endtask

  // result side: random ready gaps plus one long hold-off
  initial begin : result_sink
    int gap;
    res_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        res_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      res_ch.ready = 1'b0;
      repeat (gap) @(negedge clk);
      res_ch.ready = 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      check_result(res_ch.status, res_ch.hex_char, res_ch.last);
      @(negedge clk);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    frame_row_t row;
    int         r;
    int         force_steady;
    rst                = 1'b1;
    byte_ch.valid      = 1'b0;
    byte_ch.frame_byte = '0;
    byte_ch.first_byte = 1'b0;
    frm_pos            = '0;
    frm_sum            = '0;
    frm_err            = ST_OK;
    frm_open           = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row(FILL_ZERO, 5'b0, FRAME_LEN, 0, 1, ST_OK, CHAR_ZERO);
    add_row(FILL_ONES, 5'b0, FRAME_LEN, 2, 1, ST_OK, CHAR_F);
    add_row(FILL_RAMP, 5'b0, FRAME_LEN, 0, 0, ST_OK, '0);
    add_row(FILL_RAND, BAD_HDR, FRAME_LEN, 0, 1, ST_HDR, '0);
    add_row(FILL_RAND, BAD_TYPE, FRAME_LEN, 0, 1, ST_TYPE, '0);
    add_row(FILL_RAND, BAD_CMD, FRAME_LEN, 0, 1, ST_CMD, '0);
    add_row(FILL_RAND, BAD_SUM, FRAME_LEN, 0, 1, ST_SUM, '0);
    add_row(FILL_RAND, BAD_END, FRAME_LEN, 0, 1, ST_END, '0);
    add_row(FILL_RAND, 5'b11111, FRAME_LEN, 0, 1, ST_HDR, '0);
    add_row(FILL_RAND, BAD_TYPE | BAD_END, FRAME_LEN, 0, 1, ST_TYPE, '0);
    add_row(FILL_RAND, BAD_CMD | BAD_SUM | BAD_END, FRAME_LEN, 0, 1, ST_CMD, '0);
    add_row(FILL_RAND, BAD_SUM | BAD_END, FRAME_LEN, 0, 1, ST_SUM, '0);
    // cut short right after the first byte, then mid-frame after stray bytes
    add_row(FILL_RAND, 5'b0, 1, 0, 0, ST_OK, '0);
    add_row(FILL_RAMP, BAD_END, 15, 3, 0, ST_OK, '0);
    add_row(FILL_ONES, 5'b0, FRAME_LEN, 0, 0, ST_OK, '0);
    foreach (frame_plan_q[i]) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      send_frame(frame_plan_q[i]);
    end

    // random frames, mostly well formed; the first few go back to back under the hold-off
    hold_req     = 1'b1;
    force_steady = 4;
    frame_bytes  = 0;
    while (frame_bytes < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: row.fill = FILL_ZERO;
        1: row.fill = FILL_ONES;
        2: row.fill = FILL_RAMP;
        default: row.fill = FILL_RAND;
      endcase
      row.typed = 0;
      if (r < 70) begin
        row.bad = 5'b0;
        row.len = FRAME_LEN;
      end else if (r < 88) begin
        row.bad = 5'($urandom_range(1, 31));
        row.len = FRAME_LEN;
      end else begin
        row.bad = 5'($urandom_range(0, 31));
        row.len = $urandom_range(1, FRAME_LEN - 1);
      end
      row.stray = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
      if (force_steady > 0) begin
        tx_steady = 1;
        force_steady--;
      end else begin
        tx_steady = ($urandom_range(0, 3) == 0);
      end
      send_frame(row);
    end

    while (char_exp_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rfc_pkg.sv
rtl/rfc_byte_if.sv
rtl/rfc_res_if.sv
rtl/rfc_front.sv
rtl/rfc_queue.sv
rtl/rfc_back.sv
rtl/reader_frame_check_hex_epc.sv
sim/tb_reader_frame_check_hex_epc.sv
